@@ src/cuat_pkg.sv @@
// ----------------------------------------------------------------------------
// cuat_pkg
// Shared types, sizes and helpers for the card UID access table.
// ----------------------------------------------------------------------------
package cuat_pkg;

  localparam int NUM_SLOTS       = 10;
  localparam int UID_BYTES       = 7;
  localparam int UID_W           = 56;
  localparam int UID_FIELD_BYTES = UID_W / 8;
  localparam int LEN_W           = 3;
  localparam int USER_W          = 8;
  localparam int IDX_W           = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef enum logic [1:0] {
    KIND_LOOKUP   = 2'd0,
    KIND_ADD      = 2'd1,
    KIND_DEL_UID  = 2'd2,
    KIND_DEL_USER = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic             load;
    logic             scan;
    logic             commit;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  // keeps the first min(len, UID_BYTES) bytes of a UID
  function automatic logic [UID_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    logic [UID_W-1:0] m;
    m = '0;
    for (int b = 0; b < UID_FIELD_BYTES; b++) begin
      if (b < int'(len) && b < UID_BYTES) begin
        m[b*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

@@ src/cuat_ctrl.sv @@
// ----------------------------------------------------------------------------
// cuat_ctrl
// Request sequencer: takes a request, steps the slot index over the whole
// table, then issues one commit.
// ----------------------------------------------------------------------------
module cuat_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output cuat_pkg::cmd_t cmd
);
  import cuat_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] cnt;
  logic [IDX_W-1:0] cnt_next;
  logic             last;

  assign last = (cnt == IDX_W'(NUM_SLOTS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_SCAN;
      ST_SCAN:   if (last) state_next = ST_COMMIT;
      ST_COMMIT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.idx    = cnt;
    busy       = 1'b1;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
        cnt_next = '0;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        cnt_next = last ? '0 : cnt + 1'b1;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

@@ src/cuat_dp.sv @@
// ----------------------------------------------------------------------------
// cuat_dp
// Slot storage, request register and scan bookkeeping. One slot is compared
// per scan cycle; the table is updated once at commit.
// ----------------------------------------------------------------------------
module cuat_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  cuat_pkg::cmd_t               cmd,
  input  logic [1:0]                   kind,
  input  logic [cuat_pkg::UID_W-1:0]   uid,
  input  logic [cuat_pkg::LEN_W-1:0]   uid_len,
  input  logic [cuat_pkg::USER_W-1:0]  user,
  output logic                         done,
  output logic                         ok
);
  import cuat_pkg::*;

  logic [NUM_SLOTS-1:0] slot_valid;
  logic [UID_W-1:0]     slot_uid  [NUM_SLOTS];
  logic [LEN_W-1:0]     slot_len  [NUM_SLOTS];
  logic [USER_W-1:0]    slot_user [NUM_SLOTS];

  kind_t             req_kind;
  logic [UID_W-1:0]  req_key;
  logic [LEN_W-1:0]  req_len;
  logic [USER_W-1:0] req_user;

  logic             hit_found, user_found, free_found;
  logic [IDX_W-1:0] hit_idx, user_idx, free_idx;

  logic uid_match, user_match, slot_free;
  logic result;
  logic wr_add, wr_clr;
  logic [IDX_W-1:0] wr_idx;

  assign uid_match  = slot_valid[cmd.idx] && (slot_len[cmd.idx] == req_len) &&
                      (slot_uid[cmd.idx] == req_key);
  assign user_match = slot_valid[cmd.idx] && (slot_user[cmd.idx] == req_user);
  assign slot_free  = !slot_valid[cmd.idx];

  // request register and first-hit tracking over the scan
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind   <= kind_t'(kind);
      req_key    <= uid & byte_mask(uid_len);
      req_len    <= uid_len;
      req_user   <= user;
      hit_found  <= 1'b0;
      user_found <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.scan) begin
      if (!hit_found && uid_match) begin
        hit_found <= 1'b1;
        hit_idx   <= cmd.idx;
      end
      if (!user_found && user_match) begin
        user_found <= 1'b1;
        user_idx   <= cmd.idx;
      end
      if (!free_found && slot_free) begin
        free_found <= 1'b1;
        free_idx   <= cmd.idx;
      end
    end
  end

  always_comb begin
    result = 1'b0;
    wr_add = 1'b0;
    wr_clr = 1'b0;
    wr_idx = free_idx;
    unique case (req_kind)
      KIND_LOOKUP: result = hit_found;
      KIND_ADD: begin
        result = !hit_found && free_found;
        wr_add = result;
      end
      KIND_DEL_UID: begin
        result = hit_found;
        wr_clr = hit_found;
        wr_idx = hit_idx;
      end
      KIND_DEL_USER: begin
        result = user_found;
        wr_clr = user_found;
        wr_idx = user_idx;
      end
      default: result = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (cmd.commit && (wr_add || wr_clr)) begin
      slot_valid[wr_idx] <= wr_add;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_add) begin
      slot_uid[wr_idx]  <= req_key;
      slot_len[wr_idx]  <= req_len;
      slot_user[wr_idx] <= req_user;
    end
  end

  // result beat, one cycle wide
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      ok   <= 1'b0;
    end else begin
      done <= cmd.commit;
      ok   <= cmd.commit && result;
    end
  end

endmodule

@@ src/card_uid_access_table.sv @@
// ----------------------------------------------------------------------------
// card_uid_access_table
// Table of card UIDs with lookup, add, remove by UID and remove by user.
// ----------------------------------------------------------------------------
// start is taken in idle; the scan then compares one slot per cycle, a commit
// cycle updates the table, and done is registered from the commit.
// A new request is not taken until the previous one is done.
// busy drops in the cycle done is high, so the next start may coincide.
// Reset (rst, synchronous) empties the table and returns to idle at once.
// ----------------------------------------------------------------------------
module card_uid_access_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  kind,
  input  logic [cuat_pkg::UID_W-1:0]  uid,
  input  logic [cuat_pkg::LEN_W-1:0]  uid_len,
  input  logic [cuat_pkg::USER_W-1:0] user,
  output logic                        done,
  output logic                        ok
);
  import cuat_pkg::*;

  cmd_t cmd;

  cuat_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  cuat_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .kind    (kind),
    .uid     (uid),
    .uid_len (uid_len),
    .user    (user),
    .done    (done),
    .ok      (ok)
  );

endmodule

@@ src/cuat_checker.sv @@
// ----------------------------------------------------------------------------
// cuat_checker
// Port-level checks on the request/result sequencing of the table.
// ----------------------------------------------------------------------------
module cuat_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic ok
);

  // a taken request keeps the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after start");

  // result beat comes when the block is already free
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // one beat per request
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done longer than one cycle");

  // finishing a request always gives a result
  a_fell_done: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> done)
    else $error("busy dropped without a result");

  a_ok_qual: assert property (@(posedge clk) disable iff (rst)
    ok |-> done)
    else $error("ok without done");

endmodule

bind card_uid_access_table cuat_checker u_cuat_checker (.*);
